FILE: hdl/erfd_pkg.sv
// ----------------------------------------------------------------------------
// erfd_pkg
// Shared types and constants of the Easter-relative feast date pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package erfd_pkg;

  localparam logic [13:0] YearMin    = 14'd1583;
  localparam logic [13:0] YearMax    = 14'd9999;
  localparam logic [13:0] OutYearMin = 14'd1581;
  localparam logic [13:0] OutYearMax = 14'd10001;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  typedef struct packed {
    logic prev2;
    logic prev1;
    logic curr;
    logic next;
  } erfd_leap_t;

  typedef struct packed {
    logic [13:0]        year;
    logic signed [9:0]  offset_days;
    logic [7:0]         tidx;
    erfd_leap_t         leap;
  } erfd_easter_t;

endpackage

`default_nettype wire

FILE: hdl/erfd_computus.sv
// ----------------------------------------------------------------------------
// erfd_computus
// Eight-stage pipeline of the anonymous Gregorian computus with leap flags.
// ----------------------------------------------------------------------------
`default_nettype none

module erfd_computus (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [13:0]          year_i,
  input  wire logic signed [9:0]    offset_days_i,
  output logic                      valid_o,
  output erfd_pkg::erfd_easter_t    easter_o
);
  import erfd_pkg::*;

  function automatic logic leap_of(logic [6:0] yic, logic [6:0] cent);
    return (yic[1:0] == 2'd0) && ((yic != 7'd0) || (cent[1:0] == 2'd0));
  endfunction

  logic [7:0] vld_q, vld_d;

  // S1
  logic [13:0]       s1_year_q, s1_year_d;
  logic signed [9:0] s1_off_q;
  // S2
  logic [13:0]       s2_year_q;
  logic signed [9:0] s2_off_q;
  logic [6:0]        s2_q100_q, s2_q100_d;
  logic [9:0]        s2_q19_q, s2_q19_d;
  logic [27:0]       m100;
  logic [28:0]       m19;
  // S3
  logic [13:0]       s3_year_q;
  logic signed [9:0] s3_off_q;
  logic [6:0]        s3_cent_q, s3_yic_q, s3_yic_d;
  logic [4:0]        s3_gold_q, s3_gold_d;
  logic [2:0]        s3_corr_q;
  logic [13:0]       yic_w, gold_w;
  logic [12:0]       mc;
  // S4
  logic [13:0]       s4_year_q;
  logic signed [9:0] s4_off_q;
  logic [6:0]        s4_cent_q, s4_yic_q;
  logic [4:0]        s4_gold_q;
  logic [5:0]        s4_moon_q;
  erfd_leap_t        s4_leap_q, s4_leap_d;
  logic [14:0]       mm;
  // S5
  logic [13:0]       s5_year_q;
  logic signed [9:0] s5_off_q;
  logic [6:0]        s5_yic_q;
  logic [1:0]        s5_cr_q;
  logic [4:0]        s5_gold_q;
  logic [8:0]        s5_esum_q;
  erfd_leap_t        s5_leap_q;
  logic [9:0]        esum;
  // S6
  logic [13:0]       s6_year_q;
  logic signed [9:0] s6_off_q;
  logic [6:0]        s6_yic_q;
  logic [1:0]        s6_cr_q;
  logic [4:0]        s6_gold_q, s6_epact_q;
  erfd_leap_t        s6_leap_q;
  logic [18:0]       me;
  logic [8:0]        ep;
  // S7
  logic [13:0]       s7_year_q;
  logic signed [9:0] s7_off_q;
  logic [4:0]        s7_gold_q, s7_epact_q;
  logic [2:0]        s7_wk_q;
  erfd_leap_t        s7_leap_q;
  logic [6:0]        wsum, wr;
  logic [14:0]       mw;
  // S8
  erfd_easter_t      s8_q, s8_d;
  logic [8:0]        asum;
  logic              adj;

  assign vld_d = {vld_q[6:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    // clamp
    if (year_i < YearMin) begin
      s1_year_d = YearMin;
    end else if (year_i > YearMax) begin
      s1_year_d = YearMax;
    end else begin
      s1_year_d = year_i;
    end
    m100      = 28'(s1_year_q) * 28'd5243;
    s2_q100_d = m100[25:19];
    m19       = 29'(s1_year_q) * 29'd27595;
    s2_q19_d  = m19[28:19];
    yic_w     = s2_year_q - 14'(s2_q100_q) * 14'd100;
    gold_w    = s2_year_q - 14'(s2_q19_q) * 14'd19;
    s3_yic_d  = yic_w[6:0];
    s3_gold_d = gold_w[4:0];
    mc        = (13'(s2_q100_q) + 13'd8) * 13'd41;
    mm        = (15'(s3_cent_q) - 15'(s3_corr_q) + 15'd1) * 15'd171;
    s4_leap_d.curr = leap_of(s3_yic_q, s3_cent_q);
    if (s3_yic_q == 7'd0) begin
      s4_leap_d.prev1 = leap_of(7'd99, s3_cent_q - 7'd1);
      s4_leap_d.prev2 = leap_of(7'd98, s3_cent_q - 7'd1);
    end else if (s3_yic_q == 7'd1) begin
      s4_leap_d.prev1 = leap_of(7'd0, s3_cent_q);
      s4_leap_d.prev2 = leap_of(7'd99, s3_cent_q - 7'd1);
    end else begin
      s4_leap_d.prev1 = leap_of(s3_yic_q - 7'd1, s3_cent_q);
      s4_leap_d.prev2 = leap_of(s3_yic_q - 7'd2, s3_cent_q);
    end
    if (s3_yic_q == 7'd99) begin
      s4_leap_d.next = leap_of(7'd0, s3_cent_q + 7'd1);
    end else begin
      s4_leap_d.next = leap_of(s3_yic_q + 7'd1, s3_cent_q);
    end
    esum = 10'(s4_gold_q) * 10'd19 + 10'(s4_cent_q) - 10'(s4_cent_q[6:2])
         - 10'(s4_moon_q) + 10'd15;
    me   = 19'(s5_esum_q) * 19'd547;
    ep   = s5_esum_q - 9'(me[18:14]) * 9'd30;
    wsum = 7'd32 + 7'({s6_cr_q, 1'b0}) + 7'({s6_yic_q[6:2], 1'b0})
         - 7'(s6_epact_q) - 7'(s6_yic_q[1:0]);
    mw   = 15'(wsum) * 15'd147;
    wr   = wsum - 7'(mw[13:10]) * 7'd7;
    asum = 9'(s7_gold_q) + 9'(s7_epact_q) * 9'd11 + 9'(s7_wk_q) * 9'd22;
    adj  = (asum >= 9'd451);
    s8_d.year        = s7_year_q;
    s8_d.offset_days = s7_off_q;
    s8_d.leap        = s7_leap_q;
    s8_d.tidx        = 8'd114 + 8'(s7_epact_q) + 8'(s7_wk_q) - (adj ? 8'd7 : 8'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_year_q  <= s1_year_d;
      s1_off_q   <= offset_days_i;

      s2_year_q  <= s1_year_q;
      s2_off_q   <= s1_off_q;
      s2_q100_q  <= s2_q100_d;
      s2_q19_q   <= s2_q19_d;

      s3_year_q  <= s2_year_q;
      s3_off_q   <= s2_off_q;
      s3_cent_q  <= s2_q100_q;
      s3_yic_q   <= s3_yic_d;
      s3_gold_q  <= s3_gold_d;
      s3_corr_q  <= mc[12:10];

      s4_year_q  <= s3_year_q;
      s4_off_q   <= s3_off_q;
      s4_cent_q  <= s3_cent_q;
      s4_yic_q   <= s3_yic_q;
      s4_gold_q  <= s3_gold_q;
      s4_moon_q  <= mm[14:9];
      s4_leap_q  <= s4_leap_d;

      s5_year_q  <= s4_year_q;
      s5_off_q   <= s4_off_q;
      s5_yic_q   <= s4_yic_q;
      s5_cr_q    <= s4_cent_q[1:0];
      s5_gold_q  <= s4_gold_q;
      s5_esum_q  <= esum[8:0];
      s5_leap_q  <= s4_leap_q;

      s6_year_q  <= s5_year_q;
      s6_off_q   <= s5_off_q;
      s6_yic_q   <= s5_yic_q;
      s6_cr_q    <= s5_cr_q;
      s6_gold_q  <= s5_gold_q;
      s6_epact_q <= ep[4:0];
      s6_leap_q  <= s5_leap_q;

      s7_year_q  <= s6_year_q;
      s7_off_q   <= s6_off_q;
      s7_gold_q  <= s6_gold_q;
      s7_epact_q <= s6_epact_q;
      s7_wk_q    <= wr[2:0];
      s7_leap_q  <= s6_leap_q;

      s8_q       <= s8_d;
    end
  end

  assign valid_o  = vld_q[7];
  assign easter_o = s8_q;

endmodule

`default_nettype wire

FILE: hdl/erfd_calendar.sv
// ----------------------------------------------------------------------------
// erfd_calendar
// Four-stage pipeline: add the offset, wrap across years, split into month
// and day. The last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module erfd_calendar (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire erfd_pkg::erfd_easter_t easter_i,
  output logic                       valid_o,
  output logic [13:0]                out_year_o,
  output logic [3:0]                 out_month_o,
  output logic [4:0]                 out_day_o
);
  import erfd_pkg::*;

  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  logic [3:0] vld_q, vld_d;

  // S9
  logic signed [10:0] s9_r_q, s9_r_d;
  logic [13:0]        s9_year_q;
  erfd_leap_t         s9_leap_q;
  // S10
  logic [8:0]         s10_doy_q, s10_doy_d;
  logic [13:0]        s10_year_q, s10_year_d;
  logic               s10_leap_q, s10_leap_d;
  logic [11:0]        r12, rp1, rp2, len0, rn, sel;
  // S11
  logic [8:0]         s11_doy_q, s11_start_q, s11_start_d, cand;
  logic [13:0]        s11_year_q;
  logic [3:0]         s11_month_q, s11_month_d;
  // S12
  logic [13:0]        s12_year_q;
  logic [3:0]         s12_month_q;
  logic [4:0]         s12_day_q;
  logic [8:0]         dd;

  assign vld_d = {vld_q[2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    s9_r_d = $signed({3'b000, easter_i.tidx}) - 11'sd34
           + $signed({10'b0, easter_i.leap.curr}) + 11'(easter_i.offset_days);

    r12  = {s9_r_q[10], s9_r_q};
    rp1  = r12 + 12'd365 + 12'(s9_leap_q.prev1);
    rp2  = rp1 + 12'd365 + 12'(s9_leap_q.prev2);
    len0 = 12'd365 + 12'(s9_leap_q.curr);
    rn   = r12 - len0;
    priority if (r12[11] && rp1[11]) begin
      sel        = rp2;
      s10_year_d = s9_year_q - 14'd2;
      s10_leap_d = s9_leap_q.prev2;
    end else if (r12[11]) begin
      sel        = rp1;
      s10_year_d = s9_year_q - 14'd1;
      s10_leap_d = s9_leap_q.prev1;
    end else if (r12 >= len0) begin
      sel        = rn;
      s10_year_d = s9_year_q + 14'd1;
      s10_leap_d = s9_leap_q.next;
    end else begin
      sel        = r12;
      s10_year_d = s9_year_q;
      s10_leap_d = s9_leap_q.curr;
    end
    s10_doy_d = sel[8:0];

    s11_month_d = MonthJan;
    s11_start_d = 9'd0;
    for (int i = 1; i < 12; i++) begin
      cand = MonthStart[i] + ((i >= 2) ? 9'(s10_leap_q) : 9'd0);
      if (s10_doy_q >= cand) begin
        s11_month_d = 4'(i + 1);
        s11_start_d = cand;
      end
    end

    dd = s11_doy_q - s11_start_q + 9'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s9_r_q      <= s9_r_d;
      s9_year_q   <= easter_i.year;
      s9_leap_q   <= easter_i.leap;

      s10_doy_q   <= s10_doy_d;
      s10_year_q  <= s10_year_d;
      s10_leap_q  <= s10_leap_d;

      s11_doy_q   <= s10_doy_q;
      s11_year_q  <= s10_year_q;
      s11_month_q <= s11_month_d;
      s11_start_q <= s11_start_d;

      s12_year_q  <= s11_year_q;
      s12_month_q <= s11_month_q;
      s12_day_q   <= dd[4:0];
    end
  end

  assign valid_o     = vld_q[3];
  assign out_year_o  = s12_year_q;
  assign out_month_o = s12_month_q;
  assign out_day_o   = s12_day_q;

endmodule

`default_nettype wire

FILE: hdl/easter_relative_feast_date.sv
// ----------------------------------------------------------------------------
// easter_relative_feast_date
// Date of a feast given as a day offset from Easter Sunday of a year.
// ----------------------------------------------------------------------------
// Takes a Gregorian year (clamped to 1583..9999) and a signed day offset, and
// returns the year, month and day that lie that many days from Easter Sunday
// of that year. The pipeline has twelve register stages, and one beat is
// accepted every cycle while the output side takes results. All stages
// advance together on one enable; when a result waits at the output
// register the whole pipeline holds and in_ready_o drops in the same cycle.
`default_nettype none

module easter_relative_feast_date (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [13:0]       year_i,
  input  wire logic signed [9:0] offset_days_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [13:0]            out_year_o,
  output logic [3:0]             out_month_o,
  output logic [4:0]             out_day_o
);
  import erfd_pkg::*;

  logic         en;
  logic         cmp_valid;
  erfd_easter_t cmp_easter;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  erfd_computus u_computus (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .year_i        (year_i),
    .offset_days_i (offset_days_i),
    .valid_o       (cmp_valid),
    .easter_o      (cmp_easter)
  );

  erfd_calendar u_calendar (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (cmp_valid),
    .easter_i    (cmp_easter),
    .valid_o     (out_valid_o),
    .out_year_o  (out_year_o),
    .out_month_o (out_month_o),
    .out_day_o   (out_day_o)
  );

endmodule

`default_nettype wire

FILE: hdl/erfd_checker.sv
// ----------------------------------------------------------------------------
// erfd_checker
// Port-level checks of the feast date block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module erfd_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_o,
  input  wire logic [13:0]       year_i,
  input  wire logic signed [9:0] offset_days_i,
  input  wire logic              out_valid_o,
  input  wire logic              out_ready_i,
  input  wire logic [13:0]       out_year_o,
  input  wire logic [3:0]        out_month_o,
  input  wire logic [4:0]        out_day_o
);
  import erfd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_year_o)
      && $stable(out_month_o) && $stable(out_day_o))
    else $error("result beat changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_month_o >= MonthJan && out_month_o <= MonthDec
      && out_day_o != 5'd0)
    else $error("month or day out of range");

  a_month_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_month_o == MonthFeb && out_day_o > 5'd29)
      && !((out_month_o == MonthApr || out_month_o == MonthJun
        || out_month_o == MonthSep || out_month_o == MonthNov)
        && out_day_o == 5'd31))
    else $error("day beyond end of month");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_year_o >= OutYearMin && out_year_o <= OutYearMax)
    else $error("result year out of range");

endmodule

bind easter_relative_feast_date erfd_checker u_erfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .year_i        (year_i),
  .offset_days_i (offset_days_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_year_o    (out_year_o),
  .out_month_o   (out_month_o),
  .out_day_o     (out_day_o)
);

`default_nettype wire
